// ===== rtl/jsrt_pkg.sv =====
package jsrt_pkg;

    localparam logic [2:0] OP_CLAIM   = 3'd0;
    localparam logic [2:0] OP_RELEASE = 3'd1;
    localparam logic [2:0] OP_REQUEST = 3'd2;
    localparam logic [2:0] OP_CONSUME = 3'd3;
    localparam logic [2:0] OP_RUN     = 3'd4;
    localparam logic [2:0] OP_DONE    = 3'd5;
    localparam logic [2:0] OP_BUSY    = 3'd6;
    localparam logic [2:0] OP_DROPS   = 3'd7;

    localparam logic [2:0] MODE_FREE     = 3'd0;
    localparam logic [2:0] MODE_IDLE     = 3'd1;
    localparam logic [2:0] MODE_ARMED    = 3'd2;
    localparam logic [2:0] MODE_SCANNING = 3'd3;
    localparam logic [2:0] MODE_READY    = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_RETRY   = 2'd2;

    typedef struct packed {
        logic       pend;
        logic       rerun;
        logic [2:0] mode;
    } t_slot_ent;

    typedef struct packed {
        logic cap;
        logic rd;
        logic exec;
        logic claim_ck;
        logic scan_inc;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic is_claim;
        logic ent_free;
        logic scan_last;
    } t_dp_sts;

endpackage

// ===== rtl/jsrt_ctrl.sv =====
module jsrt_ctrl
    import jsrt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_READ    = 3'd1;
    localparam logic [2:0] S_EXEC    = 3'd2;
    localparam logic [2:0] S_SCAN_CK = 3'd3;
    localparam logic [2:0] S_DONE    = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_out_vld, n_out_vld;
    logic       w_out_free;

    assign w_out_free = !r_out_vld || i_ready;
    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = r_out_vld;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = i_sts.is_claim ? S_SCAN_CK : S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_DONE;
            end
            S_SCAN_CK: begin
                o_cmd.claim_ck = 1'b1;
                if (i_sts.ent_free || i_sts.scan_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                    n_state        = S_READ;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (o_cmd.load_out) begin
            n_out_vld = 1'b1;
        end else if (i_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> r_out_vld)
        else $error("result load did not raise output valid");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_vld || i_ready))
        else $error("pending result overwritten");

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_READ))
        else $error("accepted command did not start a slot read");

endmodule

// ===== rtl/jsrt_dp.sv =====
module jsrt_dp
    import jsrt_pkg::*;
#(
    parameter int SLOT_COUNT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    input  logic [2:0]  i_opcode,
    input  logic [7:0]  i_slot_handle,
    output logic [1:0]  o_status,
    output logic [7:0]  o_granted_handle,
    output logic        o_job_push,
    output logic [7:0]  o_job_slot,
    output logic        o_scan_go,
    output logic        o_slot_busy,
    output logic [31:0] o_drop_total
);

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    t_slot_ent r_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_vld;

    logic [2:0]    r_op;
    logic [7:0]    r_hdl;
    logic [IW-1:0] r_scan;
    t_slot_ent     r_ent;
    logic          r_ent_vld;
    logic [31:0]   r_drop;

    logic [1:0]  r_st_status;
    logic [7:0]  r_st_grant;
    logic        r_st_push;
    logic [7:0]  r_st_job;
    logic        r_st_go;
    logic        r_st_busy;
    logic [31:0] r_st_drops;

    logic          w_hdl_ok;
    logic [7:0]    w_hm1;
    logic [IW-1:0] w_idx;
    logic [IW-1:0] w_ra;
    t_slot_ent     w_ent;
    logic          w_free;
    logic          w_last;

    t_slot_ent     w_nxt;
    logic          w_we;
    logic [IW-1:0] w_wa;
    logic          w_res_ld;
    logic          w_drop_inc;
    logic [1:0]    w_status;
    logic [7:0]    w_grant;
    logic          w_push;
    logic          w_go;
    logic          w_busy;
    logic [31:0]   w_drops;

    assign w_hdl_ok = (r_hdl != 8'd0) && (r_hdl <= 8'(SLOT_COUNT));
    assign w_hm1    = r_hdl - 8'd1;
    assign w_idx    = w_hdl_ok ? w_hm1[IW-1:0] : '0;
    assign w_ra     = (r_op == OP_CLAIM) ? r_scan : w_idx;
    assign w_ent    = r_ent_vld ? r_ent : '0;
    assign w_free   = (w_ent.mode == MODE_FREE);
    assign w_last   = (r_scan == IW'(SLOT_COUNT - 1));

    assign o_sts.is_claim  = (r_op == OP_CLAIM);
    assign o_sts.ent_free  = w_free;
    assign o_sts.scan_last = w_last;

    always_comb begin
        w_nxt      = w_ent;
        w_we       = 1'b0;
        w_wa       = w_idx;
        w_res_ld   = 1'b0;
        w_drop_inc = 1'b0;
        w_status   = ST_OK;
        w_grant    = 8'd0;
        w_push     = 1'b0;
        w_go       = 1'b0;
        w_busy     = 1'b0;
        w_drops    = 32'd0;
        if (i_cmd.claim_ck) begin
            w_wa = r_scan;
            if (w_free) begin
                w_nxt.mode  = MODE_IDLE;
                w_nxt.rerun = 1'b0;
                w_we        = 1'b1;
                w_grant     = 8'(r_scan) + 8'd1;
                w_res_ld    = 1'b1;
            end else if (w_last) begin
                w_status   = ST_REFUSED;
                w_drop_inc = (r_drop != '1);
                w_res_ld   = 1'b1;
            end
        end else if (i_cmd.exec) begin
            w_res_ld = 1'b1;
            if (r_op == OP_DROPS) begin
                w_drops = r_drop;
            end else if (!w_hdl_ok) begin
                w_status = ST_REFUSED;
            end else begin
                w_we = 1'b1;
                case (r_op)
                    OP_RELEASE: begin
                        if (w_ent.mode == MODE_SCANNING) begin
                            w_status = ST_RETRY;
                        end else begin
                            w_nxt.mode = MODE_FREE;
                        end
                    end
                    OP_REQUEST: begin
                        if (w_ent.mode == MODE_IDLE) begin
                            w_nxt.mode  = MODE_ARMED;
                            w_nxt.pend  = 1'b1;
                            w_push      = !w_ent.pend;
                        end else if (w_ent.mode == MODE_FREE) begin
                            w_status = ST_REFUSED;
                        end else begin
                            w_nxt.rerun = 1'b1;
                        end
                    end
                    OP_CONSUME: begin
                        if (w_ent.mode == MODE_ARMED) begin
                            w_nxt.pend = 1'b1;
                            w_push     = !w_ent.pend;
                            w_status   = ST_REFUSED;
                        end else if (w_ent.mode == MODE_READY) begin
                            w_nxt.mode = MODE_IDLE;
                            if (w_ent.rerun) begin
                                w_nxt.rerun = 1'b0;
                                w_nxt.mode  = MODE_ARMED;
                                w_nxt.pend  = 1'b1;
                                w_push      = !w_ent.pend;
                            end
                        end else begin
                            w_status = ST_REFUSED;
                        end
                    end
                    OP_RUN: begin
                        w_nxt.pend = 1'b0;
                        if (w_ent.mode == MODE_ARMED) begin
                            w_nxt.mode = MODE_SCANNING;
                            w_go       = 1'b1;
                        end
                    end
                    OP_DONE: begin
                        if (w_ent.mode == MODE_SCANNING) begin
                            w_nxt.mode = MODE_READY;
                        end else begin
                            w_status = ST_REFUSED;
                        end
                    end
                    OP_BUSY: begin
                        w_busy = w_ent.mode inside {MODE_ARMED, MODE_SCANNING, MODE_READY};
                    end
                    default: begin
                        w_we = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_op  <= i_opcode;
            r_hdl <= i_slot_handle;
        end
        if (i_cmd.rd) begin
            r_ent     <= r_mem[w_ra];
            r_ent_vld <= r_vld[w_ra];
        end
        if (w_we) begin
            r_mem[w_wa] <= w_nxt;
        end
        if (w_res_ld) begin
            r_st_status <= w_status;
            r_st_grant  <= w_grant;
            r_st_push   <= w_push;
            r_st_job    <= w_push ? r_hdl : 8'd0;
            r_st_go     <= w_go;
            r_st_busy   <= w_busy;
            r_st_drops  <= w_drops;
        end
        if (i_cmd.load_out) begin
            o_status         <= r_st_status;
            o_granted_handle <= r_st_grant;
            o_job_push       <= r_st_push;
            o_job_slot       <= r_st_job;
            o_scan_go        <= r_st_go;
            o_slot_busy      <= r_st_busy;
            o_drop_total     <= r_st_drops;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_drop <= 32'd0;
            r_scan <= '0;
        end else begin
            if (w_we) begin
                r_vld[w_wa] <= 1'b1;
            end
            if (w_drop_inc) begin
                r_drop <= r_drop + 32'd1;
            end
            if (i_cmd.cap) begin
                r_scan <= '0;
            end else if (i_cmd.scan_inc) begin
                r_scan <= r_scan + IW'(1);
            end
        end
    end

    a_drop_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_drop >= $past(r_drop)))
        else $error("drop counter went backwards");

    a_push_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> (!r_st_push || (r_st_job == $past(r_hdl))))
        else $error("job push carries wrong slot");

endmodule

// ===== rtl/job_slot_request_tracker_core.sv =====
// job slot request tracker
// input channel: i_valid / o_ready carry i_opcode and i_slot_handle; a command
// transfers when both are high. output channel: o_valid / i_ready carry one
// result per command (status, granted handle, job push, scan go, busy, drops).
// a command is taken only while the block is idle; each command produces
// exactly one result, in order.
// the command is captured, its slot entry read, then executed, and the result
// loaded for output. claim instead reads the slot table one entry at a time
// from the lowest handle, checking each, until it finds a free entry or
// reaches the last (at most SLOT_COUNT entries looked at). a new command is
// taken only after the previous one has been loaded into the output register.
// the finished result sits in an output register; the next command can be
// taken while it waits. if the receiver stalls, the following result is held
// internally and the block stops taking commands until the register frees.
// synchronous active-low reset: all slots free, flags and drop count cleared,
// no result pending. no clearing pass is needed.
module job_slot_request_tracker_core
    import jsrt_pkg::*;
#(
    parameter int SLOT_COUNT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_opcode,
    input  logic [7:0]  i_slot_handle,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [7:0]  o_granted_handle,
    output logic        o_job_push,
    output logic [7:0]  o_job_slot,
    output logic        o_scan_go,
    output logic        o_slot_busy,
    output logic [31:0] o_drop_total
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    jsrt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    jsrt_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_opcode         (i_opcode),
        .i_slot_handle    (i_slot_handle),
        .o_status         (o_status),
        .o_granted_handle (o_granted_handle),
        .o_job_push       (o_job_push),
        .o_job_slot       (o_job_slot),
        .o_scan_go        (o_scan_go),
        .o_slot_busy      (o_slot_busy),
        .o_drop_total     (o_drop_total)
    );

endmodule

// ===== sim/job_slot_request_tracker_core_tb.sv =====
`timescale 1ns / 100ps

module job_slot_request_tracker_core_tb
    import jsrt_pkg::*;
();

    localparam int SLOTS = 16;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  granted;
        logic        push;
        logic [7:0]  job_slot;
        logic        scan_go;
        logic        busy;
        logic [31:0] drops;
    } t_slot_result;

    class slot_table_checker;
        logic [2:0]   mode [SLOTS];
        logic         rerun [SLOTS];
        logic         queued [SLOTS];
        logic [31:0]  drop_count;
        t_slot_result expected_results [$];
        int           fails;

        function new();
            int i;
            for (i = 0; i < SLOTS; i++) begin
                mode[i]   = MODE_FREE;
                rerun[i]  = 1'b0;
                queued[i] = 1'b0;
            end
            drop_count = '0;
            fails      = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // push a scan job unless one is already queued for the slot
        function void issue_job(int idx, inout t_slot_result r);
            if (!queued[idx]) begin
                queued[idx] = 1'b1;
                r.push      = 1'b1;
                r.job_slot  = 8'(idx + 1);
            end
        endfunction

        function void note_command(logic [2:0] op, logic [7:0] hdl);
            t_slot_result r;
            bit           hdl_ok;
            bit           found;
            int           idx;
            int           i;
            logic [2:0]   m;
            r      = '0;
            found  = 1'b0;
            hdl_ok = (hdl >= 8'd1) && (hdl <= 8'(SLOTS));
            idx    = hdl_ok ? int'(hdl) - 1 : 0;
            m      = mode[idx];
            if (op == OP_CLAIM) begin
                for (i = 0; i < SLOTS; i++) begin
                    if (!found && mode[i] == MODE_FREE) begin
                        found     = 1'b1;
                        mode[i]   = MODE_IDLE;
                        rerun[i]  = 1'b0;
                        r.granted = 8'(i + 1);
                    end
                end
                r.status = found ? ST_OK : ST_REFUSED;
                if (!found && drop_count != '1) begin
                    drop_count++;
                end
            end else if (op == OP_DROPS) begin
                r.drops = drop_count;
            end else if (!hdl_ok) begin
                r.status = ST_REFUSED;
            end else begin
                case (op)
                    OP_RELEASE: begin
                        if (m == MODE_SCANNING) begin
                            r.status = ST_RETRY;
                        end else begin
                            mode[idx] = MODE_FREE;
                        end
                    end
                    OP_REQUEST: begin
                        if (m == MODE_IDLE) begin
                            mode[idx] = MODE_ARMED;
                            issue_job(idx, r);
                        end else if (m == MODE_FREE) begin
                            r.status = ST_REFUSED;
                        end else begin
                            rerun[idx] = 1'b1;
                        end
                    end
                    OP_CONSUME: begin
                        if (m == MODE_ARMED) begin
                            issue_job(idx, r);
                            r.status = ST_REFUSED;
                        end else if (m == MODE_READY) begin
                            mode[idx] = MODE_IDLE;
                            if (rerun[idx]) begin
                                rerun[idx] = 1'b0;
                                mode[idx]  = MODE_ARMED;
                                issue_job(idx, r);
                            end
                        end else begin
                            r.status = ST_REFUSED;
                        end
                    end
                    OP_RUN: begin
                        queued[idx] = 1'b0;
                        if (m == MODE_ARMED) begin
                            mode[idx] = MODE_SCANNING;
                            r.scan_go = 1'b1;
                        end
                    end
                    OP_DONE: begin
                        if (m == MODE_SCANNING) begin
                            mode[idx] = MODE_READY;
                        end else begin
                            r.status = ST_REFUSED;
                        end
                    end
                    default: begin
                        r.busy = (m == MODE_ARMED) || (m == MODE_SCANNING) || (m == MODE_READY);
                    end
                endcase
            end
            expected_results.push_back(r);
        endfunction

        task report_mismatch(string what);
            if (fails < 100) begin
                $display("%0t mismatch: %s", $time, what);
            end
            fails++;
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want) begin
                report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
            end
        endtask

        task check_result(t_slot_result got);
            t_slot_result want;
            if (expected_results.size() == 0) begin
                report_mismatch("result transfer with no command outstanding");
                return;
            end
            want = expected_results.pop_front();
            compare_field("status", got.status, want.status);
            compare_field("granted_handle", got.granted, want.granted);
            compare_field("job_push", got.push, want.push);
            compare_field("job_slot", got.job_slot, want.job_slot);
            compare_field("scan_go", got.scan_go, want.scan_go);
            compare_field("slot_busy", got.busy, want.busy);
            compare_field("drop_total", got.drops, want.drops);
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_opcode = OP_CLAIM;
    logic [7:0]  i_slot_handle = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic [7:0]  o_granted_handle;
    logic        o_job_push;
    logic [7:0]  o_job_slot;
    logic        o_scan_go;
    logic        o_slot_busy;
    logic [31:0] o_drop_total;

    slot_table_checker sb;
    t_slot_result      seen_result;
    bit                no_idle = 1'b0;

    job_slot_request_tracker_core #(
        .SLOT_COUNT(SLOTS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_opcode(i_opcode),
        .i_slot_handle(i_slot_handle),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_status(o_status),
        .o_granted_handle(o_granted_handle),
        .o_job_push(o_job_push),
        .o_job_slot(o_job_slot),
        .o_scan_go(o_scan_go),
        .o_slot_busy(o_slot_busy),
        .o_drop_total(o_drop_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("job_slot_request_tracker_core_tb failed");
        $finish;
    end

    function automatic int idle_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    endfunction

    function automatic int tx_gap();
        if (no_idle || $urandom_range(0, 2) != 0) begin
            return 0;
        end
        return idle_len();
    endfunction

    // pick a command that moves the slot along its normal lifecycle
    function automatic logic [2:0] guided_op(logic [2:0] m, bit fill);
        int roll;
        roll = $urandom_range(0, 9);
        case (m)
            MODE_FREE: return OP_CLAIM;
            MODE_IDLE: return (roll < 8 || fill) ? OP_REQUEST : OP_RELEASE;
            MODE_ARMED: begin
                return roll < 6 ? OP_RUN : roll < 8 ? OP_CONSUME : roll < 9 ? OP_REQUEST : OP_BUSY;
            end
            MODE_SCANNING: begin
                return roll < 7 ? OP_DONE : roll < 9 ? OP_REQUEST : fill ? OP_BUSY : OP_RELEASE;
            end
            default: begin
                return roll < 7 ? OP_CONSUME : roll < 8 ? OP_REQUEST : roll < 9 ? OP_BUSY :
                       fill ? OP_BUSY : OP_RELEASE;
            end
        endcase
    endfunction

    task automatic send_command(logic [2:0] op, logic [7:0] hdl);
        int gap;
        gap = tx_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_opcode      <= op;
        i_slot_handle <= hdl;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_command(op, hdl);
    endtask

    task automatic send_random(bit fill);
        logic [2:0] op;
        logic [7:0] hdl;
        if ($urandom_range(0, 3) != 0) begin
            hdl = 8'($urandom_range(1, SLOTS));
            op  = guided_op(sb.mode[hdl - 1], fill);
        end else begin
            op  = 3'($urandom_range(0, 7));
            hdl = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
                  8'($urandom_range(0, SLOTS + 1));
        end
        send_command(op, hdl);
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // result side
    initial begin
        int stall;
        stall = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                i_ready <= 1'b0;
                stall--;
            end else if (!no_idle && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                stall = idle_len() - 1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            seen_result = '{status: o_status, granted: o_granted_handle, push: o_job_push,
                            job_slot: o_job_slot, scan_go: o_scan_go, busy: o_slot_busy,
                            drops: o_drop_total};
            sb.check_result(seen_result);
        end
    end

    initial begin
        int phase;
        int n;
        sb = new();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // bad handles, then one slot through its whole lifecycle
        send_command(OP_DROPS, 8'd0);
        send_command(OP_REQUEST, 8'd0);
        send_command(OP_RELEASE, 8'd255);
        send_command(OP_DONE, 8'(SLOTS + 1));
        send_command(OP_BUSY, 8'd0);
        send_command(OP_CONSUME, 8'd1);
        send_command(OP_CLAIM, 8'd0);
        send_command(OP_CONSUME, 8'd1);
        send_command(OP_REQUEST, 8'd1);
        send_command(OP_REQUEST, 8'd1);
        send_command(OP_CONSUME, 8'd1);
        send_command(OP_BUSY, 8'd1);
        send_command(OP_DONE, 8'd1);
        send_command(OP_RUN, 8'd1);
        send_command(OP_RUN, 8'd1);
        send_command(OP_RELEASE, 8'd1);
        send_command(OP_DONE, 8'd1);
        send_command(OP_CONSUME, 8'd1);
        send_command(OP_RELEASE, 8'd1);
        send_command(OP_RELEASE, 8'd1);
        send_command(OP_CLAIM, 8'd255);
        send_command(OP_REQUEST, 8'd1);
        send_command(OP_RUN, 8'(SLOTS));
        send_command(OP_DROPS, 8'hAA);
        wait_for_results();

        // phase 0 runs without gaps, phase 1 fills the table
        for (phase = 0; phase < 4; phase++) begin
            no_idle = (phase == 0);
            for (n = 0; n < 120; n++) begin
                send_random(phase == 1);
            end
            wait_for_results();
        end
        no_idle = 1'b0;

        repeat (40) @(posedge i_clk);
        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("job_slot_request_tracker_core_tb passed");
        end else begin
            $display("job_slot_request_tracker_core_tb failed");
        end
        $finish;
    end

endmodule
